// ===== hdl/sha256h_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Word types, sequencer codes, round constants and the SHA-256 bit functions.
// ----------------------------------------------------------------------------
package sha256h_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       byte_valid;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} pad_phase_t;

	localparam int unsigned ROUNDS    = 64;
	localparam int unsigned RND_W     = $clog2(ROUNDS);
	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [5:0]  LEN_START = 6'd56;
	localparam logic [5:0]  FILL_LAST = 6'd63;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

// ===== hdl/sha256h_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// 512-bit shift line: takes message bytes while filling, then steps the
// 16-word schedule window once per round.
// ----------------------------------------------------------------------------
module sha256h_sched (
	input  logic        clk,
	input  logic        ins,
	input  logic [7:0]  ins_byte,
	input  logic        step,
	output logic [31:0] w
);
	import sha256h_pkg::*;

	logic [511:0] win_q;
	logic [31:0]  w_new;

	// word 15 is w[t], word 0 is w[t+15]
	assign w_new = ssig1(win_q[32 +: 32]) + win_q[192 +: 32]
		+ ssig0(win_q[448 +: 32]) + win_q[480 +: 32];

	assign w = win_q[480 +: 32];

	always_ff @(posedge clk) begin
		if (step) begin
			win_q <= {win_q[479:0], w_new};
		end else if (ins) begin
			win_q <= {win_q[503:0], ins_byte};
		end
	end

endmodule

// ===== hdl/sha256h_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One round per cycle for 64 rounds, then a final step adding into the
// chaining value.
// ----------------------------------------------------------------------------
module sha256h_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             init,
	input  logic [31:0]      w,
	output logic             step,
	output logic             done,
	output logic [7:0][31:0] hash
);
	import sha256h_pkg::*;

	logic [7:0][31:0] hash_q;
	logic [7:0][31:0] s_q;
	logic             busy_q;
	logic             add_q;
	logic [RND_W-1:0] rnd_q;
	logic [31:0]      t1;
	logic [31:0]      t2;

	assign t1 = s_q[7] + bsig1(s_q[4]) + ch(s_q[4], s_q[5], s_q[6]) + RK[rnd_q] + w;
	assign t2 = bsig0(s_q[0]) + maj(s_q[0], s_q[1], s_q[2]);

	assign step = busy_q;
	assign done = add_q;
	assign hash = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			add_q  <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= IV[i];
			end
		end else begin
			add_q <= busy_q && (rnd_q == RND_W'(ROUNDS - 1));
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == RND_W'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (init) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= IV[i];
				end
			end else if (add_q) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + s_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= hash_q;
		end else if (busy_q) begin
			s_q <= {s_q[6:4], s_q[3] + t1, s_q[2:0], t1 + t2};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !add_q) else $error("compression started while busy");
	a_last_round_add: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (rnd_q == RND_W'(ROUNDS - 1)) |=> add_q && !busy_q)
		else $error("final add did not follow last round");

endmodule

// ===== hdl/sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message fed one byte per word and returns the eight digest words.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_ready: one word per message byte
// (byte_valid), end_of_message closes the message after its optional byte.
// A word with neither flag is taken and ignored.
// A byte is taken whenever the unit is idle. The byte completing a 64-byte
// block holds item_ready low while it is compressed: 64 rounds on the
// shared round unit, then the chaining add.
// End of message pads one byte per cycle (9 to 72 bytes), paused by one or two
// block compressions, then presents the eight digest words on
// result/result_valid/result_ready, word 0 first, one per cycle when the
// receiver takes them. The result register lets the next message start while
// the last digest word still waits; a stalled receiver holds the words.
// Reset: chaining value to the initial hash, fill and byte count cleared.
// The block buffer needs no clearing.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  sha256h_pkg::item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output sha256h_pkg::result_t result
);
	import sha256h_pkg::*;

	seq_state_t       state_q, state_d;
	pad_phase_t       pad_ph_q;
	logic             fin_q;
	logic [5:0]       fill_q;
	logic [63:0]      total_q;
	logic [63:0]      len_q;
	logic [2:0]       oidx_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             acc;
	logic             ins;
	logic [7:0]       ins_byte;
	logic             cmp_go;
	logic             load;
	logic             last_load;
	logic             step;
	logic             done;
	logic [31:0]      w;
	logic [7:0][31:0] hash;
	logic [63:0]      total_nx;

	sha256h_sched u_sched (
		.clk      (clk),
		.ins      (ins),
		.ins_byte (ins_byte),
		.step     (step),
		.w        (w)
	);

	sha256h_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_go),
		.init   (last_load),
		.w      (w),
		.step   (step),
		.done   (done),
		.hash   (hash)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign acc          = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign total_nx     = total_q + 64'(item.byte_valid);
	assign load         = (state_q == ST_OUT) && (!out_valid_q || result_ready);
	assign last_load    = load && (oidx_q == 3'd7);
	assign cmp_go       = ins && (fill_q == FILL_LAST);

	always_comb begin
		ins      = 1'b0;
		ins_byte = item.byte_value;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				ins = acc && item.byte_valid;
				if (acc) begin
					if (item.byte_valid && (fill_q == FILL_LAST)) begin
						state_d = ST_COMP;
					end else if (item.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ins = 1'b1;
				if (pad_ph_q == PH_MARK) begin
					ins_byte = PAD_MARK;
				end else if (pad_ph_q == PH_LEN || fill_q == LEN_START) begin
					ins_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
				end else begin
					ins_byte = 8'h00;
				end
				if (fill_q == FILL_LAST) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (done) begin
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (pad_ph_q == PH_LEN) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_OUT: begin
				if (last_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_ph_q    <= PH_MARK;
			fin_q       <= 1'b0;
			fill_q      <= '0;
			total_q     <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins) begin
				fill_q <= fill_q + 1'b1;
			end
			if (acc && item.byte_valid) begin
				total_q <= total_nx;
			end
			if (acc && item.end_of_message) begin
				fin_q    <= 1'b1;
				pad_ph_q <= PH_MARK;
			end else if (state_q == ST_PAD) begin
				if (pad_ph_q == PH_MARK) begin
					pad_ph_q <= PH_ZERO;
				end else if (fill_q == LEN_START) begin
					pad_ph_q <= PH_LEN;
				end
			end
			if (load) begin
				oidx_q      <= oidx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (last_load) begin
				fin_q   <= 1'b0;
				total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && item.end_of_message) begin
			len_q <= {total_nx[60:0], 3'b000};
		end
		if (load) begin
			out_q.digest_word <= hash[oidx_q];
			out_q.word_index  <= oidx_q;
			out_q.last_word   <= (oidx_q == 3'd7);
		end
	end

	a_full_block_comp: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_go |=> state_q == ST_COMP) else $error("full block did not start compression");
	a_out_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> fill_q == '0 && fin_q)
		else $error("digest output with partial block");
	a_pad_finishing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD |-> fin_q && !step) else $error("padding outside message end");

endmodule
